// File: rtl/otq_pkg.sv
`timescale 1ns / 1ps
package otq_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int TIME_W          = 48;
  localparam int TAG_W           = 16;
  localparam int PERIOD_W        = 32;
  localparam int ORDER_W         = 32;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int EMIT_W          = $clog2(MAX_RESULTS);
  localparam logic [TIME_W-1:0] MIN_DELAY = TIME_W'(100);

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef struct packed {
    logic                valid;
    logic                taken;
    logic [TAG_W-1:0]    tag;
    logic [TIME_W-1:0]   expiry;
    logic [PERIOD_W-1:0] period;
    logic [ORDER_W-1:0]  order;
  } entry_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_PASS,
    FSM_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PASS_ADD,
    PASS_FIND,
    PASS_SEARCH,
    PASS_FINAL
  } pass_t;

endpackage

// File: rtl/otq_cell.sv
`timescale 1ns / 1ps
module otq_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  otq_pkg::entry_t d,
  output otq_pkg::entry_t q
);
  import otq_pkg::*;

  entry_t ent;

  // flags reset, payload does not
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      ent.taken <= 1'b0;
    end else if (shift) begin
      ent <= d;
    end
  end

  assign q = ent;

endmodule

// File: rtl/ordered_timer_queue_unit.sv
`timescale 1ns / 1ps
// Ordered timer queue. Timers live in a ring of TABLE_DEPTH cells that rotates
// by one cell per cycle during each pass; the controller sees the head
// cell, edits it and writes it back at the tail, so one pass visits every timer.
// Input channel (in_valid/in_stall): action, tag, expire_at, interval_us, now_us.
// in_stall is low only while no item is in work.
// Output channel (out_valid/out_stall): one beat per result, last marks the
// final beat of an item. A held beat stays put while out_stall is high; the
// next result waits for it, so a stalled receiver stalls the block.
// Passes per item: add and an unknown action take one pass, cancel two
// passes, a tick firing n timers n+2 passes (n+1 when all 16 fire); each
// result then goes out as one beat. The ring walk sets the rate.
// Reset (rst, synchronous) empties the table, zeroes the order counter and
// drops any pending output beat. No clearing pass is needed.
module ordered_timer_queue_unit #(
  parameter int TABLE_DEPTH = otq_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [otq_pkg::TAG_W-1:0]    tag,
  input  logic [otq_pkg::TIME_W-1:0]   expire_at,
  input  logic [otq_pkg::PERIOD_W-1:0] interval_us,
  input  logic [otq_pkg::TIME_W-1:0]   now_us,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic                         earliest_changed,
  output logic                         fired,
  output logic [otq_pkg::TAG_W-1:0]    fired_tag,
  output logic                         queue_empty,
  output logic [otq_pkg::TIME_W-1:0]   next_delay_us,
  output logic                         last
);
  import otq_pkg::*;

  localparam int POS_W = $clog2(TABLE_DEPTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(TABLE_DEPTH - 1);

  entry_t ring [TABLE_DEPTH];
  entry_t head, head_mod;
  logic   shift;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      if (gi == TABLE_DEPTH - 1) begin : g_tail
        otq_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(head_mod), .q(ring[gi]));
      end else begin : g_mid
        otq_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(ring[gi+1]), .q(ring[gi]));
      end
    end
  endgenerate

  assign head = ring[0];

  state_t state, state_next;
  pass_t  pass, pass_next;
  logic [POS_W-1:0]    step;
  logic [TAG_W-1:0]    tag_q;
  logic [TIME_W-1:0]   when_q, now_q;
  logic [PERIOD_W-1:0] period_q;
  logic [ORDER_W-1:0]  order_counter;
  logic                inserted, old_found;
  logic [TIME_W-1:0]   old_exp;
  logic                best_found;
  logic [TIME_W-1:0]   best_exp;
  logic [ORDER_W-1:0]  best_order;
  logic [POS_W-1:0]    best_pos;
  logic [TAG_W-1:0]    best_tag;
  logic                pend, pend_reload;
  logic [POS_W-1:0]    ppos;
  logic [CNT_W-1:0]    n_fired;
  logic [EMIT_W-1:0]   emit_k;
  logic [TAG_W-1:0]    tag_buf [MAX_RESULTS];
  logic [1:0]          res_status;
  logic                res_ec;
  logic                fin_found;
  logic [TIME_W-1:0]   fin_exp;

  // per step combinational results
  logic                ins_now, elig, better, old_better;
  logic                bf_n, of_n;
  logic [TIME_W-1:0]   be_n, oe_n;
  logic [ORDER_W-1:0]  bo_n;
  logic [POS_W-1:0]    bp_n;
  logic [TAG_W-1:0]    bt_n;
  logic [TIME_W:0]     reload_sum;
  logic                hit;

  always_comb begin
    head_mod   = head;
    ins_now    = 1'b0;
    elig       = 1'b0;
    better     = 1'b0;
    old_better = 1'b0;
    reload_sum = {1'b0, now_q} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, head.period};
    hit        = pend && (step == ppos);
    case (pass)
      PASS_ADD: begin
        if (!head.valid && !inserted) begin
          head_mod = '{valid: 1'b1, taken: 1'b0, tag: tag_q, expiry: when_q,
                       period: period_q, order: order_counter};
          ins_now  = 1'b1;
        end
        elig       = head_mod.valid;
        old_better = head.valid && (!old_found || head.expiry < old_exp);
      end
      PASS_FIND: begin
        elig = head.valid && (head.tag == tag_q);
      end
      PASS_SEARCH, PASS_FINAL: begin
        if (hit) begin
          if (pend_reload && (head.period != '0)) begin
            head_mod.expiry = reload_sum[TIME_W] ? {TIME_W{1'b1}} : reload_sum[TIME_W-1:0];
          end else begin
            head_mod.valid = 1'b0;
          end
          head_mod.taken = 1'b1;
        end
        if (pass == PASS_FINAL) begin
          head_mod.taken = 1'b0;
          elig = head_mod.valid;
        end else begin
          elig = head_mod.valid && !head_mod.taken;
        end
      end
      default: elig = 1'b0;
    endcase
    if (pass == PASS_FIND) begin
      better = elig && (!best_found || head.order < best_order);
    end else begin
      better = elig && (!best_found || head_mod.expiry < best_exp ||
               (head_mod.expiry == best_exp && head_mod.order < best_order));
    end
    bf_n = best_found || better;
    be_n = better ? head_mod.expiry : best_exp;
    bo_n = better ? head_mod.order  : best_order;
    bp_n = better ? step            : best_pos;
    bt_n = better ? head_mod.tag    : best_tag;
    of_n = old_found || old_better;
    oe_n = old_better ? head.expiry : old_exp;
  end

  assign shift    = (state == FSM_PASS);
  assign in_stall = (state != FSM_IDLE);

  // result count of the item
  logic [CNT_W-1:0] res_cnt;
  logic             emit_last, out_load;
  assign res_cnt   = (n_fired != '0) ? n_fired : CNT_W'(1);
  assign emit_last = ({1'b0, emit_k} == (res_cnt - CNT_W'(1)));
  assign out_load  = (state == FSM_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    pass_next  = pass;
    case (state)
      FSM_IDLE: begin
        if (in_valid) begin
          state_next = FSM_PASS;
          case (action)
            ACT_ADD:    pass_next = PASS_ADD;
            ACT_CANCEL: pass_next = PASS_FIND;
            ACT_TICK:   pass_next = PASS_SEARCH;
            default:    pass_next = PASS_FINAL;
          endcase
        end
      end
      FSM_PASS: begin
        if (step == LAST_POS) begin
          case (pass)
            PASS_ADD:   state_next = FSM_EMIT;
            PASS_FIND:  pass_next  = PASS_FINAL;
            PASS_SEARCH: begin
              if (bf_n && be_n <= now_q && n_fired != CNT_W'(MAX_RESULTS - 1)) begin
                pass_next = PASS_SEARCH;
              end else begin
                pass_next = PASS_FINAL;
              end
            end
            PASS_FINAL: state_next = FSM_EMIT;
            default:    state_next = FSM_EMIT;
          endcase
        end
      end
      FSM_EMIT: begin
        if (out_load && emit_last) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      pass  <= PASS_FINAL;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_counter <= '0;
      step          <= '0;
      pend          <= 1'b0;
      n_fired       <= '0;
      emit_k        <= '0;
    end else begin
      case (state)
        FSM_IDLE: begin
          if (in_valid) begin
            tag_q      <= tag;
            when_q     <= expire_at;
            period_q   <= interval_us;
            now_q      <= now_us;
            step       <= '0;
            inserted   <= 1'b0;
            old_found  <= 1'b0;
            best_found <= 1'b0;
            pend       <= 1'b0;
            n_fired    <= '0;
            emit_k     <= '0;
            res_status <= ST_OK;
            res_ec     <= 1'b0;
          end
        end
        FSM_PASS: begin
          step      <= (step == LAST_POS) ? '0 : step + POS_W'(1);
          inserted  <= inserted | ins_now;
          old_found <= of_n;
          old_exp   <= oe_n;
          best_found <= (step == LAST_POS) ? 1'b0 : bf_n;
          best_exp   <= be_n;
          best_order <= bo_n;
          best_pos   <= bp_n;
          best_tag   <= bt_n;
          if (step == LAST_POS) begin
            fin_found  <= bf_n;
            fin_exp    <= be_n;
            case (pass)
              PASS_ADD: begin
                pend <= 1'b0;
                if (inserted || ins_now) begin
                  res_ec        <= !of_n || (when_q < oe_n);
                  order_counter <= order_counter + ORDER_W'(1);
                end else begin
                  res_status <= ST_FULL;
                end
              end
              PASS_FIND: begin
                if (bf_n) begin
                  pend        <= 1'b1;
                  pend_reload <= 1'b0;
                  ppos        <= bp_n;
                end else begin
                  pend       <= 1'b0;
                  res_status <= ST_ABSENT;
                end
              end
              PASS_SEARCH: begin
                if (bf_n && be_n <= now_q) begin
                  tag_buf[n_fired[EMIT_W-1:0]] <= bt_n;
                  n_fired     <= n_fired + CNT_W'(1);
                  pend        <= 1'b1;
                  pend_reload <= 1'b1;
                  ppos        <= bp_n;
                end else begin
                  pend <= 1'b0;
                end
              end
              default: pend <= 1'b0;
            endcase
          end
        end
        FSM_EMIT: begin
          if (out_load) begin
            emit_k <= emit_k + EMIT_W'(1);
          end
        end
        default: step <= '0;
      endcase
    end
  end

  // delay to the earliest remaining timer, at least MIN_DELAY, all ones when empty
  logic [TIME_W-1:0] delay_raw, delay_val;
  always_comb begin
    delay_raw = (fin_exp > now_q) ? (fin_exp - now_q) : '0;
    delay_val = (delay_raw < MIN_DELAY) ? MIN_DELAY : delay_raw;
    if (!fin_found) begin
      delay_val = {TIME_W{1'b1}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      status           <= res_status;
      earliest_changed <= res_ec;
      fired            <= (n_fired != '0);
      fired_tag        <= (n_fired != '0) ? tag_buf[emit_k] : '0;
      queue_empty      <= !fin_found;
      next_delay_us    <= delay_val;
      last             <= emit_last;
    end
  end

  a_fired_count: assert property (@(posedge clk) disable iff (rst)
    n_fired <= CNT_W'(MAX_RESULTS))
    else $error("fired count beyond limit");
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fired) |-> (status == ST_OK))
    else $error("fired beat with error status");
  a_empty_delay: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queue_empty) |-> (&next_delay_us))
    else $error("empty queue with finite delay");
  a_search_room: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_PASS && pass == PASS_SEARCH) |-> (n_fired < CNT_W'(MAX_RESULTS)))
    else $error("search pass with full fire list");
  a_order_step: assert property (@(posedge clk) disable iff (rst)
    (state != FSM_PASS) |=> (order_counter == $past(order_counter)))
    else $error("order counter moved outside a pass");

endmodule
